// ===== src/rgt_pkg.sv =====
package rgt_pkg;

    localparam int MAX_ROWS   = 16;
    localparam int MAX_COLS   = 16;
    localparam int VALUE_BITS = 32;
    localparam int IDX_W      = 4;
    localparam int CNT_W      = 5;
    localparam int ADDR_W     = 2 * IDX_W;

    typedef enum logic [2:0] {
        CMD_READ    = 3'd0,
        CMD_WRITE   = 3'd1,
        CMD_INS_ROW = 3'd2,
        CMD_INS_COL = 3'd3,
        CMD_RM_ROW  = 3'd4,
        CMD_RM_COL  = 3'd5,
        CMD_CLEAR   = 3'd6,
        CMD_NOP     = 3'd7
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_DONE  = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_FULL  = 2'd2,
        STAT_EMPTY = 2'd3
    } stat_t;

    typedef enum logic [0:0] {
        REG_START_ROWS = 1'b0,
        REG_START_COLS = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        FSM_IDLE = 2'd0,
        FSM_EXEC = 2'd1,
        FSM_RESP = 2'd2
    } fsm_t;

    typedef struct packed {
        logic [2:0]                    cmd;
        logic [IDX_W-1:0]              row_index;
        logic [IDX_W-1:0]              col_index;
        logic [CNT_W-1:0]              position;
        logic signed [VALUE_BITS-1:0]  write_value;
    } rgt_in_t;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0]  read_value;
        logic [1:0]                    status;
        logic [CNT_W-1:0]              rows_now;
        logic [CNT_W-1:0]              cols_now;
    } rgt_out_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic load_out;
    } rgt_ctrl_t;

endpackage

// ===== src/rgt_ctrl.sv =====
module rgt_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output rgt_pkg::rgt_ctrl_t ctrl
);
    import rgt_pkg::*;

    fsm_t state_reg, state_next;
    logic m_valid_reg, m_valid_next;
    logic slot_free;

    assign slot_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            FSM_IDLE: if (s_valid) state_next = FSM_EXEC;
            FSM_EXEC: state_next = FSM_RESP;
            FSM_RESP: if (slot_free) state_next = FSM_IDLE;
            default:  state_next = FSM_IDLE;
        endcase
    end

    always_comb begin
        s_ready       = (state_reg == FSM_IDLE);
        ctrl.capture  = s_ready && s_valid;
        ctrl.exec     = (state_reg == FSM_EXEC);
        ctrl.load_out = (state_reg == FSM_RESP) && slot_free;
        if (ctrl.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_valid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= FSM_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end
endmodule

// ===== src/rgt_datapath.sv =====
module rgt_datapath (
    input  logic               aclk,
    input  logic               aresetn,
    input  rgt_pkg::rgt_ctrl_t ctrl,
    input  rgt_pkg::rgt_in_t   in_data,
    input  logic               cfg_valid,
    input  logic               cfg_index,
    input  logic [4:0]         cfg_data,
    output rgt_pkg::rgt_out_t  out_data
);
    import rgt_pkg::*;

    rgt_in_t                 req_reg;
    rgt_out_t                out_reg, out_next;
    logic [CNT_W-1:0]        start_rows_reg, start_cols_reg;
    logic [CNT_W-1:0]        rows_reg, rows_next, cols_reg, cols_next;
    logic [IDX_W-1:0]        rmap_reg [MAX_ROWS];
    logic [IDX_W-1:0]        rmap_next[MAX_ROWS];
    logic [IDX_W-1:0]        cmap_reg [MAX_COLS];
    logic [IDX_W-1:0]        cmap_next[MAX_COLS];
    logic [MAX_ROWS-1:0][MAX_COLS-1:0] vld_reg, vld_next;
    logic [1:0]              st_reg, st_next;
    logic                    rd_ok_reg, rd_ok_next;
    logic                    hit_reg;
    logic [VALUE_BITS-1:0]   rd_data_reg;
    logic [VALUE_BITS-1:0]   cell_mem [MAX_ROWS*MAX_COLS];
    logic                    mem_we;
    logic [IDX_W-1:0]        prow, pcol;
    logic [ADDR_W-1:0]       addr;

    // Logical rows and columns map onto physical ones; cells hold their place.
    assign prow = rmap_reg[req_reg.row_index];
    assign pcol = cmap_reg[req_reg.col_index];
    assign addr = {prow, pcol};

    always_comb begin
        logic [IDX_W-1:0] pos4;
        logic [IDX_W-1:0] freed;
        logic [CNT_W-1:0] less;
        pos4       = req_reg.position[IDX_W-1:0];
        freed      = '0;
        less       = '0;
        rows_next  = rows_reg;
        cols_next  = cols_reg;
        rmap_next  = rmap_reg;
        cmap_next  = cmap_reg;
        vld_next   = vld_reg;
        st_next    = st_reg;
        rd_ok_next = rd_ok_reg;
        mem_we     = 1'b0;
        if (ctrl.exec) begin
            st_next    = STAT_DONE;
            rd_ok_next = 1'b0;
            case (req_reg.cmd)
                CMD_READ, CMD_WRITE: begin
                    if (rows_reg == '0 || cols_reg == '0) begin
                        st_next = STAT_EMPTY;
                    end else if ({1'b0, req_reg.row_index} >= rows_reg ||
                                 {1'b0, req_reg.col_index} >= cols_reg) begin
                        st_next = STAT_RANGE;
                    end else if (req_reg.cmd == CMD_READ) begin
                        rd_ok_next = 1'b1;
                    end else begin
                        mem_we               = 1'b1;
                        vld_next[prow][pcol] = 1'b1;
                    end
                end
                CMD_INS_ROW: begin
                    if (cols_reg == '0) begin
                        st_next = STAT_EMPTY;
                    end else if (req_reg.position > rows_reg) begin
                        st_next = STAT_RANGE;
                    end else if (rows_reg >= CNT_W'(MAX_ROWS)) begin
                        st_next = STAT_FULL;
                    end else begin
                        freed = rmap_reg[rows_reg[IDX_W-1:0]];
                        for (int i = 1; i < MAX_ROWS; i++) begin
                            if (CNT_W'(i) > req_reg.position && CNT_W'(i) <= rows_reg) begin
                                rmap_next[i] = rmap_reg[i-1];
                            end
                        end
                        rmap_next[pos4] = freed;
                        vld_next[freed] = '0;
                        rows_next       = rows_reg + 1'b1;
                    end
                end
                CMD_INS_COL: begin
                    if (rows_reg == '0) begin
                        st_next = STAT_EMPTY;
                    end else if (req_reg.position > cols_reg) begin
                        st_next = STAT_RANGE;
                    end else if (cols_reg >= CNT_W'(MAX_COLS)) begin
                        st_next = STAT_FULL;
                    end else begin
                        freed = cmap_reg[cols_reg[IDX_W-1:0]];
                        for (int i = 1; i < MAX_COLS; i++) begin
                            if (CNT_W'(i) > req_reg.position && CNT_W'(i) <= cols_reg) begin
                                cmap_next[i] = cmap_reg[i-1];
                            end
                        end
                        cmap_next[pos4] = freed;
                        for (int r = 0; r < MAX_ROWS; r++) begin
                            vld_next[r][freed] = 1'b0;
                        end
                        cols_next = cols_reg + 1'b1;
                    end
                end
                CMD_RM_ROW: begin
                    if (rows_reg == '0) begin
                        st_next = STAT_EMPTY;
                    end else if (req_reg.position >= rows_reg) begin
                        st_next = STAT_RANGE;
                    end else begin
                        less  = rows_reg - 1'b1;
                        freed = rmap_reg[pos4];
                        for (int i = 0; i < MAX_ROWS - 1; i++) begin
                            if (CNT_W'(i) >= req_reg.position && CNT_W'(i) < less) begin
                                rmap_next[i] = rmap_reg[i+1];
                            end
                        end
                        rmap_next[less[IDX_W-1:0]] = freed;
                        rows_next = less;
                        if (less == '0) cols_next = '0;
                    end
                end
                CMD_RM_COL: begin
                    if (cols_reg == '0) begin
                        st_next = STAT_EMPTY;
                    end else if (req_reg.position >= cols_reg) begin
                        st_next = STAT_RANGE;
                    end else begin
                        less  = cols_reg - 1'b1;
                        freed = cmap_reg[pos4];
                        for (int i = 0; i < MAX_COLS - 1; i++) begin
                            if (CNT_W'(i) >= req_reg.position && CNT_W'(i) < less) begin
                                cmap_next[i] = cmap_reg[i+1];
                            end
                        end
                        cmap_next[less[IDX_W-1:0]] = freed;
                        cols_next = less;
                        if (less == '0) rows_next = '0;
                    end
                end
                CMD_CLEAR: begin
                    for (int i = 0; i < MAX_ROWS; i++) rmap_next[i] = IDX_W'(i);
                    for (int i = 0; i < MAX_COLS; i++) cmap_next[i] = IDX_W'(i);
                    vld_next  = '0;
                    rows_next = (start_rows_reg > CNT_W'(MAX_ROWS)) ? CNT_W'(MAX_ROWS)
                                                                    : start_rows_reg;
                    cols_next = (start_cols_reg > CNT_W'(MAX_COLS)) ? CNT_W'(MAX_COLS)
                                                                    : start_cols_reg;
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        out_next = out_reg;
        if (ctrl.load_out) begin
            out_next.read_value = (rd_ok_reg && hit_reg) ? rd_data_reg : '0;
            out_next.status     = st_reg;
            out_next.rows_now   = rows_reg;
            out_next.cols_now   = cols_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) cell_mem[addr] <= req_reg.write_value;
        rd_data_reg <= cell_mem[addr];
        hit_reg     <= vld_reg[prow][pcol];
        if (ctrl.capture) req_reg <= in_data;
        out_reg <= out_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_rows_reg <= '0;
            start_cols_reg <= '0;
            rows_reg       <= '0;
            cols_reg       <= '0;
            vld_reg        <= '0;
            st_reg         <= STAT_DONE;
            rd_ok_reg      <= 1'b0;
            for (int i = 0; i < MAX_ROWS; i++) rmap_reg[i] <= IDX_W'(i);
            for (int i = 0; i < MAX_COLS; i++) cmap_reg[i] <= IDX_W'(i);
        end else begin
            if (cfg_valid && cfg_index == REG_START_ROWS) start_rows_reg <= cfg_data;
            if (cfg_valid && cfg_index == REG_START_COLS) start_cols_reg <= cfg_data;
            rows_reg  <= rows_next;
            cols_reg  <= cols_next;
            vld_reg   <= vld_next;
            st_reg    <= st_next;
            rd_ok_reg <= rd_ok_next;
            rmap_reg  <= rmap_next;
            cmap_reg  <= cmap_next;
        end
    end

    assign out_data = out_reg;
endmodule

// ===== src/resizable_grid_table_unit.sv =====
// Resizable grid table: a table of up to 16 x 16 signed words with a live
// row and column count.
// Requests arrive on the s_ channel (valid/ready) as one transaction each:
// read, write, insert/remove row or column, or clear. Every request returns
// exactly one result transaction on the m_ channel carrying the read word,
// a status code and the row and column counts after the request.
// The cfg_ channel writes the row and column sizes a clear request rebuilds
// the grid with; cfg_ready is always high.
// After acceptance a request goes through execute (status check, row/column
// map update, cell RAM access), then result load, which waits for a free slot.
// The single request controller accepts a new request only after the last
// one's result is loaded: accept, execute and load run in turn.
// Inserts and removes rotate small row/column maps, and per-cell valid
// bits make freshly inserted cells read as zero, so no data moves.
// Reset empties the grid, zeroes the clear sizes and finishes at once.
// When the receiver stalls, the result is held in the output register; the
// next request is still accepted and executed, then waits until the slot frees.
module resizable_grid_table_unit (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  rgt_pkg::rgt_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output rgt_pkg::rgt_out_t m_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_index,
    input  logic [4:0]        cfg_data
);
    import rgt_pkg::*;

    rgt_ctrl_t ctrl;

    assign cfg_ready = 1'b1;

    rgt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .ctrl    (ctrl)
    );

    rgt_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .in_data   (s_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_data  (m_data)
    );
endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import rgt_pkg::*;

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    rgt_in_t  s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    rgt_out_t m_data;
    logic     cfg_valid = 1'b0;
    logic     cfg_ready;
    logic     cfg_index = 1'b0;
    logic [4:0] cfg_data = '0;

    resizable_grid_table_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #2 aclk = ~aclk;

    // grid model
    logic [4:0]  clear_rows, clear_cols;
    logic [4:0]  n_rows, n_cols;
    logic [31:0] grid [MAX_ROWS][MAX_COLS];

    rgt_in_t  request_q [$];
    rgt_out_t result_q [$];
    int       mismatches = 0;
    int       cycle = 0;
    bit       calm = 1'b0;
    bit       hold_long = 1'b0;
    int       hold_count = 0;
    int       s_gap = 0;
    int       m_gap = 0;

    function automatic rgt_out_t apply_request(rgt_in_t rq);
        rgt_out_t res;
        int r, c;
        res = '0;
        res.status = STAT_DONE;
        case (cmd_t'(rq.cmd))
            CMD_READ, CMD_WRITE: begin
                if (n_rows == 0 || n_cols == 0) res.status = STAT_EMPTY;
                else if (rq.row_index >= n_rows || rq.col_index >= n_cols)
                    res.status = STAT_RANGE;
                else if (rq.cmd == CMD_READ)
                    res.read_value = grid[rq.row_index][rq.col_index];
                else grid[rq.row_index][rq.col_index] = rq.write_value;
            end
            CMD_INS_ROW: begin
                if (n_cols == 0) res.status = STAT_EMPTY;
                else if (rq.position > n_rows) res.status = STAT_RANGE;
                else if (n_rows >= MAX_ROWS) res.status = STAT_FULL;
                else begin
                    for (r = n_rows; r > rq.position; r--)
                        grid[r] = grid[r-1];
                    for (c = 0; c < MAX_COLS; c++) grid[rq.position][c] = '0;
                    n_rows++;
                end
            end
            CMD_INS_COL: begin
                if (n_rows == 0) res.status = STAT_EMPTY;
                else if (rq.position > n_cols) res.status = STAT_RANGE;
                else if (n_cols >= MAX_COLS) res.status = STAT_FULL;
                else begin
                    for (r = 0; r < MAX_ROWS; r++) begin
                        for (c = n_cols; c > rq.position; c--)
                            grid[r][c] = grid[r][c-1];
                        grid[r][rq.position] = '0;
                    end
                    n_cols++;
                end
            end
            CMD_RM_ROW: begin
                if (n_rows == 0) res.status = STAT_EMPTY;
                else if (rq.position >= n_rows) res.status = STAT_RANGE;
                else begin
                    for (r = rq.position; r + 1 < n_rows; r++) grid[r] = grid[r+1];
                    for (c = 0; c < MAX_COLS; c++) grid[n_rows-1][c] = '0;
                    n_rows--;
                    if (n_rows == 0) n_cols = 0;
                end
            end
            CMD_RM_COL: begin
                if (n_cols == 0) res.status = STAT_EMPTY;
                else if (rq.position >= n_cols) res.status = STAT_RANGE;
                else begin
                    for (r = 0; r < MAX_ROWS; r++) begin
                        for (c = rq.position; c + 1 < n_cols; c++)
                            grid[r][c] = grid[r][c+1];
                        grid[r][n_cols-1] = '0;
                    end
                    n_cols--;
                    if (n_cols == 0) n_rows = 0;
                end
            end
            CMD_CLEAR: begin
                for (r = 0; r < MAX_ROWS; r++)
                    for (c = 0; c < MAX_COLS; c++) grid[r][c] = '0;
                n_rows = clear_rows > MAX_ROWS ? MAX_ROWS : clear_rows;
                n_cols = clear_cols > MAX_COLS ? MAX_COLS : clear_cols;
            end
            default: ;
        endcase
        res.rows_now = n_rows;
        res.cols_now = n_cols;
        return res;
    endfunction

    function automatic rgt_in_t make_request(cmd_t op, int ri, int ci, int pos);
        rgt_in_t rq;
        rq.cmd = op;
        rq.row_index = IDX_W'(ri);
        rq.col_index = IDX_W'(ci);
        rq.position = CNT_W'(pos);
        rq.write_value = $urandom;
        return rq;
    endfunction

    // pick a command, biased toward well-formed grid edits
    function automatic rgt_in_t random_request();
        int k;
        cmd_t op;
        k = $urandom_range(0, 99);
        if (k < 30) op = CMD_WRITE;
        else if (k < 55) op = CMD_READ;
        else if (k < 63) op = CMD_INS_ROW;
        else if (k < 71) op = CMD_INS_COL;
        else if (k < 78) op = CMD_RM_ROW;
        else if (k < 85) op = CMD_RM_COL;
        else if (k < 90) op = CMD_CLEAR;
        else if (k < 92) op = CMD_NOP;
        else return make_request(cmd_t'($urandom_range(0, 7)), $urandom_range(0, 15),
                                 $urandom_range(0, 15), $urandom_range(0, 31));
        return make_request(op, $urandom_range(0, 15), $urandom_range(0, 15),
                            $urandom_range(0, 16));
    endfunction

    // sender
    always @(posedge aclk) begin
        if (s_valid && s_ready) begin
            result_q.push_back(apply_request(s_data));
            void'(request_q.pop_front());
        end
        if (!(s_valid && !s_ready)) begin
            if (s_gap > 0) begin
                s_gap <= s_gap - 1;
                s_valid <= 1'b0;
            end else if (request_q.size() != 0) begin
                s_valid <= 1'b1;
                s_data <= request_q[0];
                if (!calm && $urandom_range(0, 9) == 0) s_gap <= $urandom_range(1, 11);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (result_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", m_data);
            end else begin
                rgt_out_t want;
                want = result_q.pop_front();
                if (m_data !== want) begin
                    mismatches++;
                    if (mismatches <= 10) $display("mismatch: expected %p actual %p",
                                                   want, m_data);
                end
            end
        end
        if (hold_long) begin
            m_ready <= 1'b0;
        end else if (m_gap > 0) begin
            m_gap <= m_gap - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if (!calm && $urandom_range(0, 9) == 0) m_gap <= $urandom_range(1, 11);
        end
    end

    // long receiver hold-off
    always @(posedge aclk) begin
        if (hold_count > 0) begin
            hold_count <= hold_count - 1;
            if (hold_count == 1) hold_long <= 1'b0;
        end
    end

    always @(posedge aclk) begin
        cycle++;
        if (cycle > 400000) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic write_reg(cfg_reg_t idx, logic [4:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_START_ROWS) clear_rows = val;
        else clear_cols = val;
    endtask

    task automatic drain();
        while (request_q.size() != 0 || result_q.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic run_random(int count);
        repeat (count) request_q.push_back(random_request());
        drain();
    endtask

    initial begin
        int i;
        clear_rows = '0;
        clear_cols = '0;
        n_rows = '0;
        n_cols = '0;
        for (int r = 0; r < MAX_ROWS; r++)
            for (int c = 0; c < MAX_COLS; c++) grid[r][c] = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // empty grid: every command flagged, then clear with zero size
        request_q.push_back(make_request(CMD_READ, 0, 0, 0));
        request_q.push_back(make_request(CMD_WRITE, 0, 0, 0));
        request_q.push_back(make_request(CMD_INS_ROW, 0, 0, 0));
        request_q.push_back(make_request(CMD_INS_COL, 0, 0, 0));
        request_q.push_back(make_request(CMD_RM_ROW, 0, 0, 0));
        request_q.push_back(make_request(CMD_RM_COL, 0, 0, 0));
        request_q.push_back(make_request(CMD_CLEAR, 0, 0, 0));
        request_q.push_back(make_request(CMD_NOP, 15, 15, 31));
        drain();

        write_reg(REG_START_ROWS, 5'd31);
        write_reg(REG_START_COLS, 5'd16);
        request_q.push_back(make_request(CMD_CLEAR, 0, 0, 0));
        request_q.push_back(make_request(CMD_WRITE, 15, 15, 0));
        request_q.push_back(make_request(CMD_READ, 15, 15, 0));
        request_q.push_back(make_request(CMD_WRITE, 0, 0, 0));
        request_q[$].write_value = 32'h8000_0000;
        request_q.push_back(make_request(CMD_READ, 0, 0, 0));
        request_q.push_back(make_request(CMD_WRITE, 3, 4, 0));
        request_q[$].write_value = 32'h7fff_ffff;
        request_q.push_back(make_request(CMD_INS_ROW, 0, 0, 0));
        request_q.push_back(make_request(CMD_INS_COL, 0, 0, 16));
        request_q.push_back(make_request(CMD_RM_COL, 0, 0, 16));
        request_q.push_back(make_request(CMD_RM_COL, 0, 0, 2));
        request_q.push_back(make_request(CMD_INS_COL, 0, 0, 15));
        request_q.push_back(make_request(CMD_RM_ROW, 0, 0, 31));
        request_q.push_back(make_request(CMD_RM_ROW, 0, 0, 0));
        request_q.push_back(make_request(CMD_INS_ROW, 0, 0, 16));
        request_q.push_back(make_request(CMD_READ, 3, 4, 0));
        request_q.push_back(make_request(CMD_READ, 15, 0, 0));
        drain();

        write_reg(REG_START_ROWS, 5'd1);
        write_reg(REG_START_COLS, 5'd1);
        request_q.push_back(make_request(CMD_CLEAR, 0, 0, 0));
        request_q.push_back(make_request(CMD_READ, 1, 0, 0));
        request_q.push_back(make_request(CMD_RM_ROW, 0, 0, 0));
        drain();

        // random grid sizes, both start registers rewritten on each pass of the sweep
        for (i = 0; i < 10; i++) begin
            write_reg(REG_START_ROWS, (i == 9) ? 5'd0 : 5'($urandom_range(0, 31)));
            write_reg(REG_START_COLS, (i == 8) ? 5'd31 : 5'($urandom_range(1, 16)));
            request_q.push_back(make_request(CMD_CLEAR, 0, 0, 0));
            if (i == 4) begin
                // fill the block while the receiver holds off
                hold_long = 1'b1;
                hold_count = 300;
            end
            if (i == 9) calm = 1'b1;
            run_random(115);
        end

        if (mismatches == 0) $display("Test completed successfully");
        else $display("Test completed with failures");
        $finish;
    end
endmodule

// ===== sim.f =====
src/rgt_pkg.sv
src/rgt_ctrl.sv
src/rgt_datapath.sv
src/resizable_grid_table_unit.sv
bench/testbench.sv
